// ===== sv/msq_pkg.sv =====
`timescale 1ns / 1ps
package msq_pkg;

	// Operation codes of an input item.
	localparam logic [1:0] OP_CREATE   = 2'd0;
	localparam logic [1:0] OP_SET      = 2'd1;
	localparam logic [1:0] OP_CHPRI    = 2'd2;
	localparam logic [1:0] OP_SCHEDULE = 2'd3;

	// Task state codes.
	localparam logic [2:0] ST_UNUSED   = 3'd0;
	localparam logic [2:0] ST_EMBRYO   = 3'd1;
	localparam logic [2:0] ST_RUNNABLE = 3'd3;

	// Result status codes.
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NONE     = 2'd1;
	localparam logic [1:0] STAT_FULL     = 2'd2;
	localparam logic [1:0] STAT_NOTFOUND = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] CFG_PROMOTE_AGE = 2'd0;
	localparam logic [1:0] CFG_TIME_COEF   = 2'd1;
	localparam logic [1:0] CFG_CYCLE_COEF  = 2'd2;
	localparam logic [1:0] CFG_PRIO_COEF   = 2'd3;

	localparam int DEF_SLOTS = 64;
	localparam int MAX_RES   = 64;

	// Run count is kept as whole runs and tenths; it saturates at 6553.5.
	localparam logic [12:0] WHOLE_MAX = 13'd6553;
	localparam logic [3:0]  FRAC_MAX  = 4'd5;
	localparam logic [3:0]  FRAC_TOP  = 4'd9;

	// One task table entry.
	typedef struct packed {
		logic [2:0]  st;
		logic [1:0]  lvl;
		logic [17:0] arr;
		logic [12:0] whole;
		logic [3:0]  frac;
		logic [15:0] age;
		logic [15:0] pid;
	} task_t;

endpackage

// ===== sv/msq_cell.sv =====
`timescale 1ns / 1ps
module msq_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift,
	input  msq_pkg::task_t d,
	output msq_pkg::task_t q
);
	import msq_pkg::*;

	task_t entry_q;

	// The entry moves one place toward the head on every shift.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (shift) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;
endmodule

// ===== sv/multilevel_queue_scheduler_top.sv =====
`timescale 1ns / 1ps
// Multilevel queue scheduler with aging. The task table lives in a ring of SLOTS cells that
// rotates one entry per cycle, unless a level-1 grant is held for room at the output, past a
// single update unit at the head, so every operation is one or two full turns of the ring.
// Create, set_state and change_priority take one turn; a schedule round takes two (one turn
// to grant level-1 tasks and find the best level-2 and level-3 candidates, one turn to grant
// the pick and age the table). Results leave through an output register.
module multilevel_queue_scheduler_top #(
	parameter int SLOTS = msq_pkg::DEF_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [5:0]  slot,
	input  logic [15:0] pid,
	input  logic [2:0]  new_state,
	input  logic [1:0]  new_priority,
	input  logic [17:0] now_time,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [5:0]  slot_res,
	output logic [15:0] pid_res,
	output logic [1:0]  level,
	output logic        last
);
	import msq_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IW-1:0] IDX_LAST = IW'(SLOTS - 1);
	localparam int GW = $clog2(MAX_RES + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_AGE  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	// Configuration registers.
	logic [15:0] promote_q;
	logic [3:0]  tcoef_q, ccoef_q, pcoef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			promote_q <= 16'd10;
			tcoef_q   <= 4'd2;
			ccoef_q   <= 4'd2;
			pcoef_q   <= 4'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PROMOTE_AGE: promote_q <= cfg_data;
				CFG_TIME_COEF:   tcoef_q   <= cfg_data[3:0];
				CFG_CYCLE_COEF:  ccoef_q   <= cfg_data[3:0];
				CFG_PRIO_COEF:   pcoef_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Ring of cells.
	task_t cell_q [SLOTS];
	task_t head, head_new;
	logic  step;

	assign head = cell_q[0];

	for (genvar g = 0; g < SLOTS; g++) begin : g_ring
		task_t d;
		if (g == SLOTS - 1) begin : g_tail
			assign d = head_new;
		end else begin : g_mid
			assign d = cell_q[g+1];
		end
		msq_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (step),
			.d      (d),
			.q      (cell_q[g])
		);
	end

	// Control and latched item.
	logic [1:0]    fsm_q;
	logic [IW-1:0] idx_q;
	logic [1:0]    op_q;
	logic [5:0]    slot_q;
	logic [15:0]   pid_q;
	logic [2:0]    nst_q;
	logic [1:0]    npr_q;
	logic [17:0]   now_q;
	logic [15:0]   next_pid_q;
	logic          found_q;
	logic [GW-1:0] gcnt_q;
	logic          has2_q, has3_q;
	logic [IW-1:0] best2_q, best3_q;
	logic [17:0]   arr2_q;
	logic [22:0]   rank3_q;

	// Pending result: the latest grant or the final answer.
	logic        pend_v_q;
	logic [1:0]  pend_stat_q;
	logic [5:0]  pend_slot_q;
	logic [15:0] pend_pid_q;
	logic [1:0]  pend_lvl_q;

	// Output register.
	logic        out_v_q;
	logic [1:0]  out_stat_q;
	logic [5:0]  out_slot_q;
	logic [15:0] out_pid_q;
	logic [1:0]  out_lvl_q;
	logic        out_last_q;

	logic        can_push, push_v;
	logic        runnable, grant, is_l2, is_l3, pick_hit, in_xfer;
	logic [22:0] rank;
	task_t       g_e;

	assign can_push = !out_v_q || out_ready;
	assign in_ready = (fsm_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign runnable = (head.st == ST_RUNNABLE);

	assign rank = ({5'd0, head.arr} * {19'd0, tcoef_q})
		+ ({10'd0, head.whole} * {19'd0, ccoef_q})
		+ ({21'd0, head.lvl} * {19'd0, pcoef_q});

	assign is_l2 = (op_q == OP_SCHEDULE) && runnable && (head.lvl == 2'd2)
		&& (!has2_q || head.arr < arr2_q);
	assign is_l3 = (op_q == OP_SCHEDULE) && runnable && (head.lvl == 2'd3)
		&& (!has3_q || rank < rank3_q);
	// The level-2 or level-3 pick is served only when no level-1 task was granted.
	assign pick_hit = (gcnt_q == '0)
		&& ((has2_q && idx_q == best2_q) || (!has2_q && has3_q && idx_q == best3_q));

	// Update of the entry at the head of the ring.
	always_comb begin
		head_new = head;
		g_e      = head;
		grant    = 1'b0;
		// Grant applied to a copy: age cleared, one tenth added with saturation.
		g_e.age = 16'd0;
		if (!(head.whole == WHOLE_MAX && head.frac == FRAC_MAX)) begin
			if (head.frac == FRAC_TOP) begin
				g_e.frac  = 4'd0;
				g_e.whole = head.whole + 13'd1;
			end else begin
				g_e.frac = head.frac + 4'd1;
			end
		end
		if (fsm_q == S_SCAN) begin
			case (op_q)
				OP_CREATE: begin
					if (!found_q && head.st == ST_UNUSED) begin
						head_new.st    = ST_EMBRYO;
						head_new.pid   = next_pid_q;
						head_new.lvl   = 2'd2;
						head_new.age   = 16'd0;
						head_new.whole = 13'd1;
						head_new.frac  = 4'd0;
						head_new.arr   = now_q;
					end
				end
				OP_SET: begin
					if (32'(idx_q) == 32'(slot_q)) begin
						head_new.st = nst_q;
					end
				end
				OP_CHPRI: begin
					if (!found_q && head.st != ST_UNUSED && head.pid == pid_q) begin
						head_new.lvl = (npr_q == 2'd0) ? 2'd1 : npr_q;
						head_new.arr = now_q;
					end
				end
				default: begin
					if (runnable && head.lvl == 2'd1 && gcnt_q < GW'(MAX_RES)) begin
						grant    = 1'b1;
						head_new = g_e;
					end
				end
			endcase
		end else if (fsm_q == S_AGE) begin
			if (pick_hit) begin
				grant    = 1'b1;
				head_new = g_e;
			end
			if (runnable && head_new.age != 16'hFFFF) begin
				head_new.age = head_new.age + 16'd1;
			end
			if (head_new.lvl == 2'd2 && head_new.age >= promote_q) begin
				head_new.lvl = 2'd1;
				head_new.arr = now_q;
			end
		end
	end

	// A level-1 grant that displaces a pending grant needs room at the output.
	always_comb begin
		step = 1'b0;
		if (fsm_q == S_SCAN) begin
			step = !(grant && pend_v_q && !can_push);
		end else if (fsm_q == S_AGE) begin
			step = 1'b1;
		end
	end

	// The output register is loaded by a displaced grant or by the final result.
	assign push_v = (fsm_q == S_SCAN && step && grant && pend_v_q)
		|| (fsm_q == S_DONE && can_push);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q      <= S_IDLE;
			idx_q      <= '0;
			next_pid_q <= 16'd1;
			found_q    <= 1'b0;
			gcnt_q     <= '0;
			has2_q     <= 1'b0;
			has3_q     <= 1'b0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (push_v) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			case (fsm_q)
				S_IDLE: begin
					if (in_xfer) begin
						fsm_q    <= S_SCAN;
						idx_q    <= '0;
						found_q  <= 1'b0;
						gcnt_q   <= '0;
						has2_q   <= 1'b0;
						has3_q   <= 1'b0;
						pend_v_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (step) begin
						idx_q <= (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
						if (op_q == OP_CREATE && !found_q && head.st == ST_UNUSED) begin
							found_q     <= 1'b1;
							pend_slot_q <= 6'(idx_q);
							pend_pid_q  <= next_pid_q;
							next_pid_q  <= (next_pid_q == 16'hFFFF) ? 16'd1
								: next_pid_q + 16'd1;
						end
						if (op_q == OP_CHPRI && !found_q && head.st != ST_UNUSED
								&& head.pid == pid_q) begin
							found_q <= 1'b1;
						end
						if (is_l2) begin
							has2_q  <= 1'b1;
							best2_q <= idx_q;
							arr2_q  <= head.arr;
						end
						if (is_l3) begin
							has3_q  <= 1'b1;
							best3_q <= idx_q;
							rank3_q <= rank;
						end
						if (grant) begin
							// Earlier grant goes out; it is not the final result.
							if (pend_v_q) begin
								out_stat_q <= pend_stat_q;
								out_slot_q <= pend_slot_q;
								out_pid_q  <= pend_pid_q;
								out_lvl_q  <= pend_lvl_q;
								out_last_q <= 1'b0;
							end
							pend_v_q    <= 1'b1;
							pend_stat_q <= STAT_OK;
							pend_slot_q <= 6'(idx_q);
							pend_pid_q  <= head.pid;
							pend_lvl_q  <= head.lvl;
							gcnt_q      <= gcnt_q + 1'b1;
						end
						if (idx_q == IDX_LAST) begin
							fsm_q <= (op_q == OP_SCHEDULE) ? S_AGE : S_DONE;
						end
					end
				end
				S_AGE: begin
					idx_q <= (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
					if (grant) begin
						pend_v_q    <= 1'b1;
						pend_stat_q <= STAT_OK;
						pend_slot_q <= 6'(idx_q);
						pend_pid_q  <= head.pid;
						pend_lvl_q  <= head.lvl;
					end
					if (idx_q == IDX_LAST) begin
						fsm_q <= S_DONE;
					end
				end
				default: begin
					// Final result of the item.
					if (can_push) begin
						out_last_q <= 1'b1;
						fsm_q      <= S_IDLE;
						case (op_q)
							OP_CREATE: begin
								out_stat_q <= found_q ? STAT_OK : STAT_FULL;
								out_slot_q <= found_q ? pend_slot_q : 6'd0;
								out_pid_q  <= found_q ? pend_pid_q : 16'd0;
								out_lvl_q  <= 2'd0;
							end
							OP_SET: begin
								out_stat_q <= STAT_OK;
								out_slot_q <= 6'd0;
								out_pid_q  <= 16'd0;
								out_lvl_q  <= 2'd0;
							end
							OP_CHPRI: begin
								out_stat_q <= found_q ? STAT_OK : STAT_NOTFOUND;
								out_slot_q <= 6'd0;
								out_pid_q  <= 16'd0;
								out_lvl_q  <= 2'd0;
							end
							default: begin
								out_stat_q <= pend_v_q ? pend_stat_q : STAT_NONE;
								out_slot_q <= pend_v_q ? pend_slot_q : 6'd0;
								out_pid_q  <= pend_v_q ? pend_pid_q : 16'd0;
								out_lvl_q  <= pend_v_q ? pend_lvl_q : 2'd0;
							end
						endcase
					end
				end
			endcase
		end
	end

	// Item capture.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q   <= op;
			slot_q <= slot;
			pid_q  <= pid;
			nst_q  <= new_state;
			npr_q  <= new_priority;
			now_q  <= now_time;
		end
	end

	assign out_valid = out_v_q;
	assign status    = out_stat_q;
	assign slot_res  = out_slot_q;
	assign pid_res   = out_pid_q;
	assign level     = out_lvl_q;
	assign last      = out_last_q;
endmodule

// ===== bench/tb_multilevel_queue_scheduler_top.sv =====
`timescale 1ns / 1ps
module tb_multilevel_queue_scheduler_top;
	import msq_pkg::*;

	localparam int NSLOT = 64;
	localparam int WATCH_LIMIT = 20000;

	typedef struct packed {
		logic [1:0]  st;
		logic [5:0]  sl;
		logic [15:0] pd;
		logic [1:0]  lv;
		logic        lst;
	} sched_res_t;

	typedef struct {
		logic [1:0]  op;
		logic [5:0]  sl;
		logic [15:0] pd;
		logic [2:0]  ns;
		logic [1:0]  np;
		logic [17:0] tm;
		bit          typed;
		logic [1:0]  exp_st;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] op = '0;
	logic [5:0] slot = '0;
	logic [15:0] pid = '0;
	logic [2:0] new_state = '0;
	logic [1:0] new_priority = 2'd1;
	logic [17:0] now_time = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic [5:0] slot_res;
	logic [15:0] pid_res;
	logic [1:0] level;
	logic last;

	multilevel_queue_scheduler_top dut (.*);

	always #10 clk = ~clk;

	// Shadow copy of the task table and registers.
	logic [2:0]  m_state [NSLOT];
	logic [1:0]  m_level [NSLOT];
	logic [17:0] m_arr [NSLOT];
	logic [15:0] m_tenths [NSLOT];
	logic [15:0] m_age [NSLOT];
	logic [15:0] m_pid [NSLOT];
	logic [15:0] m_next_pid;
	logic [15:0] r_promote;
	logic [3:0]  r_tcoef, r_ccoef, r_pcoef;

	sched_res_t expected_q[$];
	int errors = 0;
	int idle_cycles = 0;
	logic [15:0] pid_pool[$];

	function automatic logic [63:0] level3_rank(int i);
		return 64'(m_arr[i]) * r_tcoef + 64'(m_tenths[i] / 10) * r_ccoef
			+ 64'(m_level[i]) * r_pcoef;
	endfunction

	function automatic sched_res_t mk(logic [1:0] s, logic [5:0] sl, logic [15:0] pd,
		logic [1:0] lv);
		sched_res_t r;
		r.st = s; r.sl = sl; r.pd = pd; r.lv = lv; r.lst = 1'b0;
		return r;
	endfunction

	function automatic sched_res_t grant_task(int i);
		m_age[i] = '0;
		if (m_tenths[i] != 16'hFFFF)
			m_tenths[i]++;
		return mk(STAT_OK, 6'(i), m_pid[i], m_level[i]);
	endfunction

	// Predict the results of one operation and queue them.
	task automatic predict_op(input stim_row_t t);
		sched_res_t res[$];
		int f;
		int pick;
		res = {};
		f = -1;
		pick = -1;
		case (t.op)
			OP_CREATE: begin
				for (int i = 0; i < NSLOT; i++)
					if (f < 0 && m_state[i] == ST_UNUSED) f = i;
				if (f < 0) res.push_back(mk(STAT_FULL, 0, 0, 0));
				else begin
					m_state[f] = ST_EMBRYO; m_pid[f] = m_next_pid; m_level[f] = 2;
					m_age[f] = 0; m_tenths[f] = 10; m_arr[f] = t.tm;
					m_next_pid = (m_next_pid == 16'hFFFF) ? 16'd1 : m_next_pid + 1;
					pid_pool.push_back(m_pid[f]);
					res.push_back(mk(STAT_OK, 6'(f), m_pid[f], 0));
				end
			end
			OP_SET: begin
				m_state[t.sl] = t.ns;
				res.push_back(mk(STAT_OK, 0, 0, 0));
			end
			OP_CHPRI: begin
				for (int i = 0; i < NSLOT; i++)
					if (f < 0 && m_state[i] != ST_UNUSED && m_pid[i] == t.pd) f = i;
				if (f < 0) res.push_back(mk(STAT_NOTFOUND, 0, 0, 0));
				else begin
					m_level[f] = (t.np == 0) ? 2'd1 : t.np;
					m_arr[f] = t.tm;
					res.push_back(mk(STAT_OK, 0, 0, 0));
				end
			end
			default: begin
				for (int i = 0; i < NSLOT; i++)
					if (res.size() < MAX_RES && m_state[i] == ST_RUNNABLE && m_level[i] == 1)
						res.push_back(grant_task(i));
				if (res.size() == 0) begin
					for (int i = 0; i < NSLOT; i++)
						if (m_state[i] == ST_RUNNABLE && m_level[i] == 2 &&
							(pick < 0 || m_arr[i] < m_arr[pick])) pick = i;
					if (pick < 0)
						for (int i = 0; i < NSLOT; i++)
							if (m_state[i] == ST_RUNNABLE && m_level[i] == 3 &&
								(pick < 0 || level3_rank(i) < level3_rank(pick))) pick = i;
					if (pick >= 0) res.push_back(grant_task(pick));
				end
				if (res.size() == 0) res.push_back(mk(STAT_NONE, 0, 0, 0));
				// Aging and promotion of waiting level-2 tasks.
				for (int i = 0; i < NSLOT; i++) begin
					if (m_state[i] == ST_RUNNABLE && m_age[i] != 16'hFFFF) m_age[i]++;
					if (m_level[i] == 2 && m_age[i] >= r_promote) begin
						m_level[i] = 1; m_arr[i] = t.tm;
					end
				end
			end
		endcase
		res[res.size() - 1].lst = 1'b1;
		if (t.typed && res[0].st != t.exp_st) begin
			$display("%0t: typed status expected %0d predicted %0d", $time, t.exp_st,
				res[0].st);
			errors++;
		end
		foreach (res[k]) expected_q.push_back(res[k]);
	endtask

	// Output side: random stalls, and compare each transfer with the oldest expectation.
	always @(posedge clk) begin
		sched_res_t got, want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '{status, slot_res, pid_res, level, last};
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					errors++;
				end else begin
					want = expected_q.pop_front();
					if (got.st != want.st) begin
						$display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
						errors++;
					end
					if (got.sl != want.sl) begin
						$display("%0t: slot_res expected %0d actual %0d", $time, want.sl, got.sl);
						errors++;
					end
					if (got.pd != want.pd) begin
						$display("%0t: pid_res expected %0d actual %0d", $time, want.pd, got.pd);
						errors++;
					end
					if (got.lv != want.lv) begin
						$display("%0t: level expected %0d actual %0d", $time, want.lv, got.lv);
						errors++;
					end
					if (got.lst != want.lst) begin
						$display("%0t: last expected %0d actual %0d", $time, want.lst, got.lst);
						errors++;
					end
				end
			end
			if ($urandom_range(0, 3) == 0) out_ready <= 1'b1;
			else if ($urandom_range(0, 99) < 3) out_ready <= 1'b0;
			else if ($urandom_range(0, 99) < 30) out_ready <= ($urandom_range(0, 1) == 1);
		end
	end

	// Watchdog on cycles with no transfer on either channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// One register write; the write enable is low again before the task returns.
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_PROMOTE_AGE: r_promote = val;
			CFG_TIME_COEF: r_tcoef = val[3:0];
			CFG_CYCLE_COEF: r_ccoef = val[3:0];
			default: r_pcoef = val[3:0];
		endcase
		@(posedge clk);
	endtask

	task automatic drain();
		while (expected_q.size() != 0) @(posedge clk);
		repeat (3 * NSLOT) @(posedge clk);
	endtask

	// The gap is never empty, so valid drops before the next item is driven.
	task automatic send(input stim_row_t t);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
		repeat (gap) @(posedge clk);
		in_valid <= 1'b1;
		op <= t.op; slot <= t.sl; pid <= t.pd;
		new_state <= t.ns; new_priority <= t.np; now_time <= t.tm;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_op(t);
		in_valid <= 1'b0;
	endtask

	function automatic stim_row_t row(logic [1:0] o, logic [5:0] s, logic [15:0] p,
		logic [2:0] n, logic [1:0] r, logic [17:0] tm, bit ty, logic [1:0] es);
		stim_row_t t;
		t.op = o; t.sl = s; t.pd = p; t.ns = n; t.np = r; t.tm = tm;
		t.typed = ty; t.exp_st = es;
		return t;
	endfunction

	function automatic stim_row_t rand_item();
		stim_row_t t;
		int sel;
		sel = $urandom_range(0, 99);
		t.typed = 0; t.exp_st = 0;
		t.sl = $urandom_range(0, 63);
		t.pd = (pid_pool.size() != 0 && $urandom_range(0, 3) != 0) ?
			pid_pool[$urandom_range(0, pid_pool.size() - 1)] : 16'($urandom);
		t.ns = ($urandom_range(0, 2) != 0) ? ST_RUNNABLE : 3'($urandom_range(0, 7));
		t.np = $urandom_range(0, 3);
		t.tm = $urandom_range(0, 235959);
		if ($urandom_range(0, 19) == 0) t.tm = 18'($urandom);
		if (sel < 15) t.op = OP_CREATE;
		else if (sel < 45) t.op = OP_SET;
		else if (sel < 60) t.op = OP_CHPRI;
		else t.op = OP_SCHEDULE;
		if (t.op == OP_SET && $urandom_range(0, 1) == 1) t.sl = $urandom_range(0, 15);
		return t;
	endfunction

	stim_row_t dir_rows[$];
	stim_row_t rt;

	initial begin
		for (int i = 0; i < NSLOT; i++) begin
			m_state[i] = 0; m_level[i] = 0; m_arr[i] = 0;
			m_tenths[i] = 0; m_age[i] = 0; m_pid[i] = 0;
		end
		m_next_pid = 1;
		r_promote = 10; r_tcoef = 2; r_ccoef = 2; r_pcoef = 2;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2 * NSLOT + 4) @(posedge clk);

		// Directed table: empty table, creates, states, priorities, ties, levels.
		dir_rows = '{
			row(OP_SCHEDULE, 0, 0, 0, 1, 0, 1, STAT_NONE),
			row(OP_CHPRI, 0, 16'hFFFF, 0, 1, 0, 1, STAT_NOTFOUND),
			row(OP_CREATE, 0, 0, 0, 1, 18'd235959, 1, STAT_OK),
			row(OP_CREATE, 0, 0, 0, 1, 18'd0, 1, STAT_OK),
			row(OP_CREATE, 0, 0, 0, 1, 18'd0, 1, STAT_OK),
			row(OP_CREATE, 0, 0, 0, 1, 18'h3FFFF, 1, STAT_OK),
			row(OP_SET, 0, 0, ST_RUNNABLE, 1, 0, 1, STAT_OK),
			row(OP_SET, 1, 0, ST_RUNNABLE, 1, 0, 1, STAT_OK),
			row(OP_SET, 2, 0, ST_RUNNABLE, 1, 0, 1, STAT_OK),
			row(OP_SCHEDULE, 0, 0, 0, 1, 18'd5, 0, 0),
			row(OP_CHPRI, 0, 16'd3, 0, 2'd3, 18'd7, 1, STAT_OK),
			row(OP_CHPRI, 0, 16'd2, 0, 2'd3, 18'd7, 1, STAT_OK),
			row(OP_CHPRI, 0, 16'd1, 0, 2'd0, 18'd9, 1, STAT_OK),
			row(OP_SCHEDULE, 0, 0, 0, 1, 18'd10, 0, 0),
			row(OP_SET, 0, 0, 3'd7, 1, 0, 1, STAT_OK),
			row(OP_SCHEDULE, 0, 0, 0, 1, 18'd11, 0, 0),
			row(OP_SET, 63, 0, 3'd6, 1, 0, 1, STAT_OK),
			row(OP_SET, 3, 0, ST_RUNNABLE, 1, 0, 1, STAT_OK),
			row(OP_SCHEDULE, 0, 0, 0, 1, 18'd12, 0, 0),
			row(OP_SET, 2, 0, 3'd0, 1, 0, 1, STAT_OK),
			row(OP_CREATE, 0, 0, 0, 1, 18'd100, 1, STAT_OK),
			row(OP_SCHEDULE, 0, 0, 0, 1, 18'd13, 0, 0)
		};
		foreach (dir_rows[k]) send(dir_rows[k]);

		// Fill the table for the full case and a round with many level-1 grants.
		drain();
		write_reg(CFG_PROMOTE_AGE, 16'd1);
		for (int i = 0; i < NSLOT + 1; i++)
			send(row(OP_CREATE, 0, 0, 0, 1, 18'($urandom_range(0, 235959)), 0, 0));
		for (int i = 0; i < NSLOT; i++) send(row(OP_SET, 6'(i), 0, ST_RUNNABLE, 1, 0, 0, 0));
		repeat (3) send(row(OP_SCHEDULE, 0, 0, 0, 1, 18'd1000, 0, 0));
		for (int i = 0; i < NSLOT; i++)
			send(row(OP_SET, 6'(i), 0, ($urandom_range(0, 3) == 0) ? 3'd0 : 3'd2, 1, 0, 0, 0));

		// Random phases through several register settings, extremes included.
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			case (ph)
				0: begin
					write_reg(CFG_PROMOTE_AGE, 16'hFFFF); write_reg(CFG_TIME_COEF, 0);
					write_reg(CFG_CYCLE_COEF, 0); write_reg(CFG_PRIO_COEF, 0);
				end
				1: begin
					write_reg(CFG_PROMOTE_AGE, 16'd1); write_reg(CFG_TIME_COEF, 15);
					write_reg(CFG_CYCLE_COEF, 15); write_reg(CFG_PRIO_COEF, 15);
				end
				2: begin
					write_reg(CFG_PROMOTE_AGE, 16'd10); write_reg(CFG_TIME_COEF, 2);
					write_reg(CFG_CYCLE_COEF, 2); write_reg(CFG_PRIO_COEF, 2);
				end
				default: begin
					write_reg(CFG_PROMOTE_AGE, 16'($urandom_range(1, 30)));
					write_reg(CFG_TIME_COEF, 16'($urandom_range(0, 15)));
					write_reg(CFG_CYCLE_COEF, 16'($urandom_range(0, 15)));
					write_reg(CFG_PRIO_COEF, 16'($urandom_range(0, 15)));
				end
			endcase
			repeat (40) begin
				rt = rand_item();
				send(rt);
			end
		end

		// End of run: wait for every expected result, then a tail of quiet cycles.
		while (expected_q.size() != 0) @(posedge clk);
		repeat (3 * NSLOT) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
